/* hw/rtl/rgbfrs_pkg.sv */
// shared types, codes and constants of the rgb444 frame ring store
package rgbfrs_pkg;

  // default geometry
  localparam int SLOTS_DEF  = 4;
  localparam int WIDTH_DEF  = 100;
  localparam int HEIGHT_DEF = 100;

  // field widths
  localparam int CMD_W     = 3;
  localparam int COORD_W   = 7;
  localparam int SAMPLE_W  = 8;
  localparam int NIB_W     = 4;
  localparam int PIX_W     = 12;
  localparam int STATUS_W  = 2;
  localparam int OFF_W     = 5;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;

  // signed width used for position arithmetic
  localparam int CALC_W = 13;

  // commands
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REWIND  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNREADABLE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_X  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_Y  = 3'd6;

  // mode flag bits
  localparam int MODE_OFFSET   = 0;
  localparam int MODE_MIRROR_X = 1;
  localparam int MODE_MIRROR_Y = 2;

  // offset reset values
  localparam logic signed [OFF_W-1:0] RED_X_RST   = 5'sd5;
  localparam logic signed [OFF_W-1:0] RED_Y_RST   = 5'sd0;
  localparam logic signed [OFF_W-1:0] GREEN_X_RST = 5'sd0;
  localparam logic signed [OFF_W-1:0] GREEN_Y_RST = 5'sd4;
  localparam logic signed [OFF_W-1:0] BLUE_X_RST  = -5'sd3;
  localparam logic signed [OFF_W-1:0] BLUE_Y_RST  = -5'sd3;

  // channel clear masks
  localparam logic [15:0] RED_CLEAR   = 16'hF0FF;
  localparam logic [15:0] GREEN_CLEAR = 16'hFF0F;
  localparam logic [15:0] BLUE_CLEAR  = 16'hFFF0;

  // channel numbers in offset mode
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // slot ring commands
  typedef struct packed {
    logic commit;
    logic release_slot;
    logic rewind;
  } slot_cmd_t;

  // slot ring status
  typedef struct packed {
    logic wr_busy;
    logic rd_ok;
    logic empty;
    logic wr_free;
  } slot_flags_t;

endpackage

/* hw/rtl/rgbfrs_pixel_mem.sv */
// pixel memory with registered read and a zero sweep after reset
module rgbfrs_pixel_mem #(
  parameter int DEPTH = rgbfrs_pkg::SLOTS_DEF * rgbfrs_pkg::WIDTH_DEF * rgbfrs_pkg::HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [rgbfrs_pkg::PIX_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rgbfrs_pkg::PIX_W-1:0] wr_data,
  output logic                         busy
);

  localparam int PW = rgbfrs_pkg::PIX_W;

  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_data_r;
  logic [AW-1:0] clr_addr_r;
  logic          clearing_r;

  // clear sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // write port, shared with the sweep
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

/* hw/rtl/rgbfrs_pos_calc.sv */
// pixel position: offset, clamp, mirror and channel enable
module rgbfrs_pos_calc #(
  parameter int FRAME_WIDTH  = rgbfrs_pkg::WIDTH_DEF,
  parameter int FRAME_HEIGHT = rgbfrs_pkg::HEIGHT_DEF,
  parameter int XW           = $clog2(FRAME_WIDTH),
  parameter int YW           = $clog2(FRAME_HEIGHT)
) (
  input  logic [rgbfrs_pkg::COORD_W-1:0]      column,
  input  logic [rgbfrs_pkg::COORD_W-1:0]      row,
  input  logic signed [rgbfrs_pkg::OFF_W-1:0] off_x,
  input  logic signed [rgbfrs_pkg::OFF_W-1:0] off_y,
  input  logic                                use_off,
  input  logic                                mirror_x,
  input  logic                                mirror_y,
  output logic [XW-1:0]                       pos_x,
  output logic [YW-1:0]                       pos_y,
  output logic                                enable
);

  localparam int CW = rgbfrs_pkg::CALC_W;
  localparam logic signed [CW-1:0] XMAX = CW'(FRAME_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(FRAME_HEIGHT - 1);

  logic signed [CW-1:0] col_s, row_s, ox_s, oy_s;
  logic signed [CW-1:0] sum_x, sum_y, clp_x, clp_y, fin_x, fin_y;

  always_comb begin
    col_s = $signed(CW'(column));
    row_s = $signed(CW'(row));
    ox_s  = use_off ? CW'(off_x) : '0;
    oy_s  = use_off ? CW'(off_y) : '0;
    sum_x = col_s + ox_s;
    sum_y = row_s + oy_s;

    // clamp into the frame
    if (sum_x < 0) clp_x = '0;
    else if (sum_x > XMAX) clp_x = XMAX;
    else clp_x = sum_x;
    if (sum_y < 0) clp_y = '0;
    else if (sum_y > YMAX) clp_y = YMAX;
    else clp_y = sum_y;

    // mirror
    fin_x = mirror_x ? (XMAX - clp_x) : clp_x;
    fin_y = mirror_y ? (YMAX - clp_y) : clp_y;

    enable = !use_off || ((row_s >= oy_s) && (col_s >= ox_s));
  end

  assign pos_x = XW'(fin_x);
  assign pos_y = YW'(fin_y);

endmodule

/* hw/rtl/rgbfrs_slot_ring.sv */
// ring of frame slots: readable marks, write and read slot pointers
module rgbfrs_slot_ring #(
  parameter int FRAME_SLOTS = rgbfrs_pkg::SLOTS_DEF,
  parameter int SW          = $clog2(FRAME_SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rgbfrs_pkg::slot_cmd_t   cmd,
  output rgbfrs_pkg::slot_flags_t flags,
  output logic [SW-1:0]           write_slot,
  output logic [SW-1:0]           read_slot
);

  logic [FRAME_SLOTS-1:0] readable_r, readable_nxt;
  logic [SW-1:0]          ws_r, ws_nxt, rs_r, rs_nxt;
  logic [SW-1:0]          ws_inc, rs_inc;

  // wrapping increments
  assign ws_inc = (ws_r == SW'(FRAME_SLOTS - 1)) ? '0 : ws_r + 1'b1;
  assign rs_inc = (rs_r == SW'(FRAME_SLOTS - 1)) ? '0 : rs_r + 1'b1;

  // command update
  always_comb begin
    readable_nxt = readable_r;
    ws_nxt       = ws_r;
    rs_nxt       = rs_r;
    if (cmd.commit) begin
      readable_nxt[ws_r] = 1'b1;
      ws_nxt             = ws_inc;
    end else if (cmd.release_slot) begin
      if (|readable_r) begin
        readable_nxt[rs_r] = 1'b0;
        rs_nxt             = rs_inc;
      end
    end else if (cmd.rewind) begin
      rs_nxt = '0;
      for (int s = 0; s < FRAME_SLOTS; s++) begin
        if (SW'(s) < ws_r) readable_nxt[s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      readable_r <= '0;
      ws_r       <= '0;
      rs_r       <= '0;
    end else begin
      readable_r <= readable_nxt;
      ws_r       <= ws_nxt;
      rs_r       <= rs_nxt;
    end
  end

  // status toward the sequencer
  always_comb begin
    flags.wr_busy = readable_r[ws_r];
    flags.rd_ok   = readable_r[rs_r];
    flags.empty   = ~|readable_r;
    flags.wr_free = ~readable_r[ws_inc];
  end

  assign write_slot = ws_r;
  assign read_slot  = rs_r;

endmodule

/* hw/rtl/rgb444_frame_ring_store.sv */
// top level: command sequencer, configuration registers and result register
//
// Usage: commands enter on the in_ channel (valid/stall) and each gives
// exactly one transaction on the out_ channel (valid/stall). Registers are
// written on the cfg_ channel (valid/ready, ready always high); the user is
// to write them only while idle, which the block does not enforce. One
// command is in work at a time. States from acceptance to result:
//   commit, release, rewind, refused accesses: EXEC, DONE
//   plain pixel write: EXEC, CALC, ADDR, ACCESS, DONE; pixel read adds MODIFY
//   offset-mode write: EXEC, per enabled channel CALC, ADDR, ACCESS, MODIFY (a
//   read, modify and write on the single port pair), per skipped CALC, then DONE
// The next command can be taken from the cycle after the result is loaded.
// After reset the pixel memory is swept to zero, one entry a cycle, over all
// FRAME_SLOTS * FRAME_WIDTH * FRAME_HEIGHT entries (40000 by default); no
// command is taken until the sweep ends, configuration writes are taken.
// When the receiver stalls, the result is held in the output register; a
// new command may be accepted but its result waits for the register.
module rgb444_frame_ring_store #(
  parameter int FRAME_SLOTS  = rgbfrs_pkg::SLOTS_DEF,
  parameter int FRAME_WIDTH  = rgbfrs_pkg::WIDTH_DEF,
  parameter int FRAME_HEIGHT = rgbfrs_pkg::HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rgbfrs_pkg::CMD_W-1:0]      in_cmd,
  input  logic [rgbfrs_pkg::COORD_W-1:0]    in_column,
  input  logic [rgbfrs_pkg::COORD_W-1:0]    in_row,
  input  logic [rgbfrs_pkg::SAMPLE_W-1:0]   in_red_in,
  input  logic [rgbfrs_pkg::SAMPLE_W-1:0]   in_green_in,
  input  logic [rgbfrs_pkg::SAMPLE_W-1:0]   in_blue_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rgbfrs_pkg::PIX_W-1:0]      out_pixel_out,
  output logic [rgbfrs_pkg::STATUS_W-1:0]   out_status,
  output logic                              out_write_slot_free,
  output logic                              out_frame_readable,
  output logic                              out_buffer_empty,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbfrs_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int DEPTH = FRAME_SLOTS * FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(FRAME_SLOTS);
  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);
  localparam int PW    = rgbfrs_pkg::PIX_W;
  localparam int NW    = rgbfrs_pkg::NIB_W;
  localparam int OW    = rgbfrs_pkg::OFF_W;
  localparam int CW    = rgbfrs_pkg::CALC_W;

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_CALC   = 3'd3;
  localparam logic [2:0] S_ADDR   = 3'd4;
  localparam logic [2:0] S_ACCESS = 3'd5;
  localparam logic [2:0] S_MODIFY = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [rgbfrs_pkg::MODE_W-1:0] mode_r;
  logic signed [OW-1:0] rx_r, ry_r, gx_r, gy_r, bx_r, by_r;
  logic any_off, off_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      rx_r   <= rgbfrs_pkg::RED_X_RST;
      ry_r   <= rgbfrs_pkg::RED_Y_RST;
      gx_r   <= rgbfrs_pkg::GREEN_X_RST;
      gy_r   <= rgbfrs_pkg::GREEN_Y_RST;
      bx_r   <= rgbfrs_pkg::BLUE_X_RST;
      by_r   <= rgbfrs_pkg::BLUE_Y_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rgbfrs_pkg::REG_MODE:    mode_r <= cfg_data[rgbfrs_pkg::MODE_W-1:0];
        rgbfrs_pkg::REG_RED_X:   rx_r   <= $signed(cfg_data);
        rgbfrs_pkg::REG_RED_Y:   ry_r   <= $signed(cfg_data);
        rgbfrs_pkg::REG_GREEN_X: gx_r   <= $signed(cfg_data);
        rgbfrs_pkg::REG_GREEN_Y: gy_r   <= $signed(cfg_data);
        rgbfrs_pkg::REG_BLUE_X:  bx_r   <= $signed(cfg_data);
        rgbfrs_pkg::REG_BLUE_Y:  by_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign any_off  = (rx_r != 0) || (ry_r != 0) || (gx_r != 0) ||
                    (gy_r != 0) || (bx_r != 0) || (by_r != 0);
  assign off_mode = mode_r[rgbfrs_pkg::MODE_OFFSET] && any_off;

  // captured command
  logic [rgbfrs_pkg::CMD_W-1:0]   cmd_r;
  logic [rgbfrs_pkg::COORD_W-1:0] col_r, row_r;
  logic [NW-1:0]                  r4_r, g4_r, b4_r;
  logic                           in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd;
      col_r <= in_column;
      row_r <= in_row;
      r4_r  <= in_red_in[rgbfrs_pkg::SAMPLE_W-1 -: NW];
      g4_r  <= in_green_in[rgbfrs_pkg::SAMPLE_W-1 -: NW];
      b4_r  <= in_blue_in[rgbfrs_pkg::SAMPLE_W-1 -: NW];
    end
  end

  // slot ring
  rgbfrs_pkg::slot_cmd_t   ring_cmd;
  rgbfrs_pkg::slot_flags_t ring_flags;
  logic [SW-1:0]           write_slot, read_slot;

  rgbfrs_slot_ring #(
    .FRAME_SLOTS (FRAME_SLOTS),
    .SW          (SW)
  ) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ring_cmd),
    .flags      (ring_flags),
    .write_slot (write_slot),
    .read_slot  (read_slot)
  );

  // per-operation registers
  logic          op_read_r, op_read_nxt;
  logic          op_plain_r, op_plain_nxt;
  logic [1:0]    ch_r, ch_nxt;
  logic [SW-1:0] op_slot_r, op_slot_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [PW-1:0] pix_r, pix_nxt;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [AW-1:0] addr_r;
  logic          coord_ok;

  assign coord_ok = (CW'(col_r) < CW'(FRAME_WIDTH)) && (CW'(row_r) < CW'(FRAME_HEIGHT));

  // position of the current channel or pixel
  logic signed [OW-1:0] sel_ox, sel_oy;
  logic [XW-1:0]        calc_x;
  logic [YW-1:0]        calc_y;
  logic                 calc_en;
  logic                 calc_off;

  always_comb begin
    case (ch_r)
      rgbfrs_pkg::CH_RED: begin
        sel_ox = rx_r;
        sel_oy = ry_r;
      end
      rgbfrs_pkg::CH_GREEN: begin
        sel_ox = gx_r;
        sel_oy = gy_r;
      end
      default: begin
        sel_ox = bx_r;
        sel_oy = by_r;
      end
    endcase
  end

  assign calc_off = !op_read_r && !op_plain_r;

  rgbfrs_pos_calc #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .XW           (XW),
    .YW           (YW)
  ) u_pos (
    .column   (col_r),
    .row      (row_r),
    .off_x    (sel_ox),
    .off_y    (sel_oy),
    .use_off  (calc_off),
    .mirror_x (!op_read_r && mode_r[rgbfrs_pkg::MODE_MIRROR_X]),
    .mirror_y (!op_read_r && mode_r[rgbfrs_pkg::MODE_MIRROR_Y]),
    .pos_x    (calc_x),
    .pos_y    (calc_y),
    .enable   (calc_en)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_CALC) begin
      x_r <= calc_x;
      y_r <= calc_y;
    end
    if (state_r == S_ADDR) begin
      addr_r <= AW'(op_slot_r) * AW'(FRAME_WIDTH * FRAME_HEIGHT)
              + AW'(x_r) * AW'(FRAME_HEIGHT) + AW'(y_r);
    end
  end

  // pixel memory
  logic          mem_busy, mem_rd_en, mem_wr_en;
  logic [PW-1:0] mem_rd_data, mem_wr_data, merged;

  rgbfrs_pixel_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (addr_r),
    .wr_data (mem_wr_data),
    .busy    (mem_busy)
  );

  // nibble merge of the current channel
  always_comb begin
    case (ch_r)
      rgbfrs_pkg::CH_RED:
        merged = (mem_rd_data & PW'(rgbfrs_pkg::RED_CLEAR)) | {r4_r, {(2*NW){1'b0}}};
      rgbfrs_pkg::CH_GREEN:
        merged = (mem_rd_data & PW'(rgbfrs_pkg::GREEN_CLEAR)) | {{NW{1'b0}}, g4_r, {NW{1'b0}}};
      default:
        merged = (mem_rd_data & PW'(rgbfrs_pkg::BLUE_CLEAR)) | {{(2*NW){1'b0}}, b4_r};
    endcase
  end

  // output register
  logic            out_valid_r;
  logic [PW-1:0]   out_pix_r;
  logic [1:0]      out_status_r;
  logic            out_free_r, out_readable_r, out_empty_r;
  logic            out_load;

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    op_read_nxt  = op_read_r;
    op_plain_nxt = op_plain_r;
    ch_nxt       = ch_r;
    op_slot_nxt  = op_slot_r;
    status_nxt   = status_r;
    pix_nxt      = pix_r;
    ring_cmd     = '0;
    mem_rd_en    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_wr_data  = merged;
    unique case (state_r)
      S_CLEAR: begin
        if (!mem_busy) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        status_nxt   = rgbfrs_pkg::ST_OK;
        pix_nxt      = '0;
        op_read_nxt  = 1'b0;
        op_plain_nxt = 1'b0;
        ch_nxt       = rgbfrs_pkg::CH_RED;
        state_nxt    = S_DONE;
        unique case (cmd_r)
          rgbfrs_pkg::CMD_WRITE: begin
            op_slot_nxt = write_slot;
            if (!coord_ok) begin
              status_nxt = rgbfrs_pkg::ST_RANGE;
            end else if (ring_flags.wr_busy) begin
              status_nxt = rgbfrs_pkg::ST_BUSY;
            end else begin
              op_plain_nxt = !off_mode;
              state_nxt    = S_CALC;
            end
          end
          rgbfrs_pkg::CMD_COMMIT: begin
            ring_cmd.commit = 1'b1;
          end
          rgbfrs_pkg::CMD_READ: begin
            op_slot_nxt = read_slot;
            if (!coord_ok) begin
              status_nxt = rgbfrs_pkg::ST_RANGE;
            end else if (!ring_flags.rd_ok) begin
              status_nxt = rgbfrs_pkg::ST_UNREADABLE;
            end else begin
              op_read_nxt = 1'b1;
              state_nxt   = S_CALC;
            end
          end
          rgbfrs_pkg::CMD_RELEASE: begin
            ring_cmd.release_slot = 1'b1;
            if (ring_flags.empty) status_nxt = rgbfrs_pkg::ST_UNREADABLE;
          end
          rgbfrs_pkg::CMD_REWIND: begin
            ring_cmd.rewind = 1'b1;
          end
          default: ;
        endcase
      end
      S_CALC: begin
        if (calc_en) begin
          state_nxt = S_ADDR;
        end else if (ch_r == rgbfrs_pkg::CH_BLUE) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_ADDR: begin
        state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        if (op_plain_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = {r4_r, g4_r, b4_r};
          state_nxt   = S_DONE;
        end else begin
          mem_rd_en = 1'b1;
          state_nxt = S_MODIFY;
        end
      end
      S_MODIFY: begin
        if (op_read_r) begin
          pix_nxt   = mem_rd_data;
          state_nxt = S_DONE;
        end else begin
          mem_wr_en = 1'b1;
          if (ch_r == rgbfrs_pkg::CH_BLUE) begin
            state_nxt = S_DONE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_read_r  <= op_read_nxt;
    op_plain_r <= op_plain_nxt;
    ch_r       <= ch_nxt;
    op_slot_r  <= op_slot_nxt;
    status_r   <= status_nxt;
    pix_r      <= pix_nxt;
  end

  // result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r      <= pix_r;
      out_status_r   <= status_r;
      out_free_r     <= ring_flags.wr_free;
      out_readable_r <= ring_flags.rd_ok;
      out_empty_r    <= ring_flags.empty;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_out       = out_pix_r;
  assign out_status          = out_status_r;
  assign out_write_slot_free = out_free_r;
  assign out_frame_readable  = out_readable_r;
  assign out_buffer_empty    = out_empty_r;

endmodule

/* dv/testbench.sv */
// self-checking testbench for the rgb444 frame ring store
module testbench;
  import rgbfrs_pkg::*;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int WIDTH       = WIDTH_DEF;
  localparam int HEIGHT      = HEIGHT_DEF;
  localparam int PHASES      = 10;
  localparam int PHASE_CMDS  = 140;
  localparam int IDLE_PCT    = 16;
  localparam int QUIET_LIMIT = 200000;
  localparam int SETTLE_CYC  = 20;
  localparam int DRAIN_CYC   = 40;
  localparam int MAX_REPORTS = 10;
  // first code that has no operation behind it
  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } pixel_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    logic [STATUS_W-1:0] status;
    logic                wr_free;
    logic                readable;
    logic                empty;
  } store_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd      = '0;
  logic [COORD_W-1:0]   in_column   = '0;
  logic [COORD_W-1:0]   in_row      = '0;
  logic [SAMPLE_W-1:0]  in_red_in   = '0;
  logic [SAMPLE_W-1:0]  in_green_in = '0;
  logic [SAMPLE_W-1:0]  in_blue_in  = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [PIX_W-1:0]     out_pixel_out;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_write_slot_free;
  logic                 out_frame_readable;
  logic                 out_buffer_empty;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;

  rgb444_frame_ring_store uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_red_in           (in_red_in),
    .in_green_in         (in_green_in),
    .in_blue_in          (in_blue_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pixel_out       (out_pixel_out),
    .out_status          (out_status),
    .out_write_slot_free (out_write_slot_free),
    .out_frame_readable  (out_frame_readable),
    .out_buffer_empty    (out_buffer_empty),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // shadow copy of the frame ring and its registers
  logic [PIX_W-1:0]          frame_mem [SLOTS*WIDTH*HEIGHT];
  logic [SLOTS-1:0]          slot_ready_mask = '0;
  int                        rd_slot = 0;
  int                        wr_slot = 0;
  logic [MODE_W-1:0]         mode_reg = '0;
  logic signed [OFF_W-1:0]   chan_ofs [6];

  pixel_cmd_t    cmd_queue [$];
  store_result_t expected_results [$];
  pixel_cmd_t    live_cmd;
  int            cmds_taken = 0;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  logic          calm;

  // a stretch of the run with no idling on either side
  assign calm = (cmds_taken >= 600) && (cmds_taken < 850);

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pix_addr(int slot, int x, int y);
    return slot * WIDTH * HEIGHT + x * HEIGHT + y;
  endfunction

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // one nibble at its offset, clamped and mirrored position
  function automatic void put_channel(int col, int row, logic [1:0] ch,
                                      logic [NIB_W-1:0] nib);
    int ox, oy, x, y, a;
    logic [15:0] clear_mask, bits;
    ox = chan_ofs[2 * int'(ch)];
    oy = chan_ofs[2 * int'(ch) + 1];
    if (!(row >= oy && col >= ox)) return;
    x = clamp_to(col + ox, WIDTH - 1);
    y = clamp_to(row + oy, HEIGHT - 1);
    if (mode_reg[MODE_MIRROR_X]) x = WIDTH - 1 - x;
    if (mode_reg[MODE_MIRROR_Y]) y = HEIGHT - 1 - y;
    case (ch)
      CH_RED: begin
        clear_mask = RED_CLEAR;
        bits = {4'h0, nib, 8'h00};
      end
      CH_GREEN: begin
        clear_mask = GREEN_CLEAR;
        bits = {8'h00, nib, 4'h0};
      end
      default: begin
        clear_mask = BLUE_CLEAR;
        bits = {12'h000, nib};
      end
    endcase
    a = pix_addr(wr_slot, x, y);
    frame_mem[a] = (frame_mem[a] & clear_mask[PIX_W-1:0]) | bits[PIX_W-1:0];
  endfunction

  // advance the shadow store by one command and give its result
  function automatic store_result_t step_store(input pixel_cmd_t c);
    store_result_t res;
    int col, row, x, y;
    logic coord_ok, any_ofs;
    logic [NIB_W-1:0] r4, g4, b4;
    res = '0;
    col = c.column;
    row = c.row;
    r4 = c.red[SAMPLE_W-1 -: NIB_W];
    g4 = c.green[SAMPLE_W-1 -: NIB_W];
    b4 = c.blue[SAMPLE_W-1 -: NIB_W];
    coord_ok = (col < WIDTH) && (row < HEIGHT);
    case (c.cmd)
      CMD_WRITE: begin
        if (!coord_ok) begin
          res.status = ST_RANGE;
        end else if (slot_ready_mask[wr_slot]) begin
          res.status = ST_BUSY;
        end else begin
          any_ofs = 1'b0;
          for (int k = 0; k < 6; k++) if (chan_ofs[k] != 0) any_ofs = 1'b1;
          if (mode_reg[MODE_OFFSET] && any_ofs) begin
            put_channel(col, row, CH_RED, r4);
            put_channel(col, row, CH_GREEN, g4);
            put_channel(col, row, CH_BLUE, b4);
          end else begin
            x = mode_reg[MODE_MIRROR_X] ? WIDTH - 1 - col : col;
            y = mode_reg[MODE_MIRROR_Y] ? HEIGHT - 1 - row : row;
            frame_mem[pix_addr(wr_slot, x, y)] = {r4, g4, b4};
          end
        end
      end
      CMD_COMMIT: begin
        slot_ready_mask[wr_slot] = 1'b1;
        wr_slot = (wr_slot + 1) % SLOTS;
      end
      CMD_READ: begin
        if (!coord_ok) res.status = ST_RANGE;
        else if (!slot_ready_mask[rd_slot]) res.status = ST_UNREADABLE;
        else res.pixel = frame_mem[pix_addr(rd_slot, col, row)];
      end
      CMD_RELEASE: begin
        if (slot_ready_mask == '0) begin
          res.status = ST_UNREADABLE;
        end else begin
          slot_ready_mask[rd_slot] = 1'b0;
          rd_slot = (rd_slot + 1) % SLOTS;
        end
      end
      CMD_REWIND: begin
        rd_slot = 0;
        for (int s = 0; s < wr_slot; s++) slot_ready_mask[s] = 1'b1;
      end
      default: ;
    endcase
    res.wr_free  = !slot_ready_mask[(wr_slot + 1) % SLOTS];
    res.readable = slot_ready_mask[rd_slot];
    res.empty    = (slot_ready_mask == '0);
    return res;
  endfunction

  function automatic pixel_cmd_t mk_cmd(logic [CMD_W-1:0] cmd, int col, int row,
                                        int r, int g, int b);
    pixel_cmd_t c;
    c.cmd    = cmd;
    c.column = COORD_W'(col);
    c.row    = COORD_W'(row);
    c.red    = SAMPLE_W'(r);
    c.green  = SAMPLE_W'(g);
    c.blue   = SAMPLE_W'(b);
    return c;
  endfunction

  // coordinates crowd the frame edges so reads hit written pixels
  function automatic int rand_coord();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return $urandom_range(0, 9);
    if (p < 55) return $urandom_range(WIDTH - 10, WIDTH - 1);
    if (p < 90) return $urandom_range(0, WIDTH - 1);
    return $urandom_range(WIDTH, (1 << COORD_W) - 1);
  endfunction

  // mostly writes and reads, with commits and releases balanced
  function automatic pixel_cmd_t rand_cmd();
    int p;
    logic [CMD_W-1:0] cmd;
    p = $urandom_range(0, 99);
    if (p < 45) cmd = CMD_WRITE;
    else if (p < 72) cmd = CMD_READ;
    else if (p < 82) cmd = CMD_COMMIT;
    else if (p < 92) cmd = CMD_RELEASE;
    else if (p < 97) cmd = CMD_REWIND;
    else cmd = CMD_W'($urandom_range(CMD_SPARE, (1 << CMD_W) - 1));
    return mk_cmd(cmd, rand_coord(), rand_coord(), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  // register write transaction, shadow updated when taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MODE) mode_reg = val[MODE_W-1:0];
    else chan_ofs[int'(idx) - int'(REG_RED_X)] = val;
  endtask

  // register settings of each phase
  task automatic configure(input int ph);
    logic [MODE_W-1:0] m;
    logic [OFF_W-1:0]  o [6];
    case (ph)
      0: m = '0;
      1: m = 3'b001;
      2: m = 3'b111;
      3: m = 3'b011;
      4: m = 3'b001;
      5: m = 3'b101;
      6: m = 3'b110;
      7: m = 3'b001;
      default: m = MODE_W'($urandom_range(0, 7));
    endcase
    case (ph)
      0, 1: begin
        o[0] = RED_X_RST;   o[1] = RED_Y_RST;
        o[2] = GREEN_X_RST; o[3] = GREEN_Y_RST;
        o[4] = BLUE_X_RST;  o[5] = BLUE_Y_RST;
      end
      2: for (int k = 0; k < 6; k++) o[k] = 5'b10000;
      3: for (int k = 0; k < 6; k++) o[k] = 5'b01111;
      4: for (int k = 0; k < 6; k++) o[k] = '0;
      7: begin
        // one lone nonzero offset still selects offset mode
        for (int k = 0; k < 5; k++) o[k] = '0;
        o[5] = '1;
      end
      default: for (int k = 0; k < 6; k++) o[k] = OFF_W'($urandom_range(0, 31));
    endcase
    write_reg(REG_MODE, {2'($urandom_range(0, 3)), m});
    for (int k = 0; k < 6; k++) write_reg(CFG_IDX_W'(int'(REG_RED_X) + k), o[k]);
    cfg_valid <= 1'b0;
  endtask

  // stimulus and end of run
  initial begin
    for (int i = 0; i < SLOTS * WIDTH * HEIGHT; i++) frame_mem[i] = '0;
    chan_ofs[0] = RED_X_RST;   chan_ofs[1] = RED_Y_RST;
    chan_ofs[2] = GREEN_X_RST; chan_ofs[3] = GREEN_Y_RST;
    chan_ofs[4] = BLUE_X_RST;  chan_ofs[5] = BLUE_Y_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYC) @(posedge clk);
      configure(ph);
      if (ph == 0) begin
        // sample extremes, out of range coordinates, refused accesses
        cmd_queue.push_back(mk_cmd(CMD_WRITE, 0, 0, 255, 255, 255));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, WIDTH - 1, HEIGHT - 1, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, 0, HEIGHT - 1, 'h0f, 'hf0, 'h80));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, WIDTH, 5, 255, 255, 255));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, 5, 127, 255, 255, 255));
        cmd_queue.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_RELEASE, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_COMMIT, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_READ, WIDTH - 1, HEIGHT - 1, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_READ, 0, HEIGHT - 1, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_READ, 127, 0, 0, 0, 0));
        // fill the ring so the write slot becomes busy
        repeat (3) cmd_queue.push_back(mk_cmd(CMD_COMMIT, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, 1, 1, 255, 255, 255));
        cmd_queue.push_back(mk_cmd(CMD_SPARE, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd({CMD_W{1'b1}}, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_RELEASE, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_READ, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_REWIND, 0, 0, 0, 0, 0));
        // drain the ring, then release on an empty ring
        repeat (5) cmd_queue.push_back(mk_cmd(CMD_RELEASE, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk_cmd(CMD_WRITE, 0, 0, 255, 255, 255));
      end
      repeat (PHASE_CMDS) cmd_queue.push_back(rand_cmd());
    end
    while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(step_store(live_cmd));
        cmds_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          live_cmd = cmd_queue.pop_front();
          in_cmd      <= live_cmd.cmd;
          in_column   <= live_cmd.column;
          in_row      <= live_cmd.row;
          in_red_in   <= live_cmd.red;
          in_green_in <= live_cmd.green;
          in_blue_in  <= live_cmd.blue;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    store_result_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_pixel_out, out_status, out_write_slot_free,
               out_frame_readable, out_buffer_empty};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transaction: pixel %h status %0d flags %b%b%b",
                     got.pixel, got.status, got.wr_free, got.readable, got.empty);
        end else begin
          want = expected_results.pop_front();
          if (got.pixel !== want.pixel || got.status !== want.status ||
              got.wr_free !== want.wr_free || got.readable !== want.readable ||
              got.empty !== want.empty) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: expected pixel %h status %0d free %b readable %b ",
                        "empty %b, got pixel %h status %0d free %b readable %b empty %b"},
                       want.pixel, want.status, want.wr_free, want.readable, want.empty,
                       got.pixel, got.status, got.wr_free, got.readable, got.empty);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
